FILE: rtl/core/mcop_pkg.sv
// Shared types and constants for the midpoint circle octant plotter.
// Holds the octet queue entry, the per-pixel plan table and colour codes.
// No dependencies.
`default_nettype none

package mcop_pkg;

    // Colour codes
    localparam logic [1:0] GREEN  = 2'd0;
    localparam logic [1:0] RED    = 2'd1;
    localparam logic [1:0] YELLOW = 2'd2;
    localparam logic [1:0] BLUE   = 2'd3;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Geometry widths
    localparam int ARC_W = 10;
    localparam int DEC_W = 13;
    // Wide enough for any supported coordinate width plus a carry
    localparam int SUM_W = 17;

    // Index of the last of the eight pixels of an octet
    localparam logic [2:0] LAST_IDX = 3'd7;

    // Octet queue geometry
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One octet to be drawn: current point, centre and final-octet flag
    typedef struct packed {
        logic [ARC_W-1:0] arc_x;
        logic [ARC_W-1:0] arc_y;
        logic [ARC_W-1:0] cen_col;
        logic [ARC_W-1:0] cen_row;
        logic             done;
    } t_octet;

    // How one pixel of the octet is formed from (x, y)
    typedef struct packed {
        logic       swap;     // column takes y, row takes x
        logic       neg_col;  // subtract the column offset
        logic       neg_row;  // subtract the row offset
        logic [1:0] colour;
    } t_plan;

    function automatic t_plan pixel_plan(input logic [2:0] idx);
        t_plan p;
        unique case (idx)
            3'd0: p = '{swap: 1'b0, neg_col: 1'b0, neg_row: 1'b1, colour: GREEN};
            3'd1: p = '{swap: 1'b1, neg_col: 1'b0, neg_row: 1'b1, colour: GREEN};
            3'd2: p = '{swap: 1'b1, neg_col: 1'b0, neg_row: 1'b0, colour: GREEN};
            3'd3: p = '{swap: 1'b0, neg_col: 1'b0, neg_row: 1'b0, colour: RED};
            3'd4: p = '{swap: 1'b0, neg_col: 1'b1, neg_row: 1'b0, colour: YELLOW};
            3'd5: p = '{swap: 1'b1, neg_col: 1'b1, neg_row: 1'b0, colour: GREEN};
            3'd6: p = '{swap: 1'b1, neg_col: 1'b1, neg_row: 1'b1, colour: GREEN};
            3'd7: p = '{swap: 1'b0, neg_col: 1'b1, neg_row: 1'b1, colour: BLUE};
            default: p = '{swap: 1'b0, neg_col: 1'b0, neg_row: 1'b0, colour: GREEN};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mcop_front.sv
// Front end: accepts items, keeps the midpoint state and classifies each item.
// Emitting items are pushed as one octet entry into the queue.
// Depends on mcop_pkg.
`default_nettype none

module mcop_front import mcop_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_action,
    input  wire logic [ARC_W-1:0] i_center_x,
    input  wire logic [ARC_W-1:0] i_center_y,
    input  wire logic [ARC_W-1:0] i_radius,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output t_octet                o_entry
);

    logic [ARC_W-1:0] r_arc_x, n_arc_x;
    logic [ARC_W-1:0] r_arc_y, n_arc_y;
    logic [DEC_W-1:0] r_dec, n_dec;
    logic [ARC_W-1:0] r_cen_col, r_cen_row;
    logic             r_drawing;

    logic             is_start, emit, accept;
    logic [ARC_W-1:0] x_cur, y_cur, col_cur, row_cur;
    logic [DEC_W-1:0] d_cur;
    logic [ARC_W:0]   nx;
    logic [ARC_W+1:0] nx_s, ny_s, diff;
    logic             done;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Select the point to draw: fresh circle on start, stored point otherwise
    assign is_start = (i_action == ACT_START);
    assign emit     = is_start || r_drawing;
    assign x_cur    = is_start ? '0 : r_arc_x;
    assign y_cur    = is_start ? i_radius : r_arc_y;
    assign col_cur  = is_start ? i_center_x : r_cen_col;
    assign row_cur  = is_start ? i_center_y : r_cen_row;
    assign d_cur    = is_start ? (DEC_W'(1) - {{(DEC_W-ARC_W){1'b0}}, i_radius}) : r_dec;

    // Advance the point and the decision variable
    assign nx   = {1'b0, x_cur} + (ARC_W+1)'(1);
    assign nx_s = {1'b0, nx};
    assign ny_s = d_cur[DEC_W-1] ? {2'b00, y_cur} : ({2'b00, y_cur} - (ARC_W+2)'(1));
    assign diff = nx_s - ny_s;
    assign done = $signed(nx_s) >= $signed(ny_s);

    always_comb begin
        n_arc_x = nx[ARC_W-1:0];
        n_arc_y = ny_s[ARC_W-1:0];
        if (d_cur[DEC_W-1]) begin
            n_dec = d_cur + {{(DEC_W-ARC_W-2){1'b0}}, nx, 1'b1};
        end else begin
            n_dec = d_cur + {diff[DEC_W-2:0], 1'b1};
        end
    end

    // Hand the octet to the queue
    assign o_push  = accept && emit;
    assign o_entry = '{arc_x: x_cur, arc_y: y_cur, cen_col: col_cur,
                       cen_row: row_cur, done: done};

    // Update the circle state on every emitting item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arc_x   <= '0;
            r_arc_y   <= '0;
            r_dec     <= '0;
            r_cen_col <= '0;
            r_cen_row <= '0;
            r_drawing <= 1'b0;
        end else if (accept && emit) begin
            r_arc_x   <= n_arc_x;
            r_arc_y   <= n_arc_y;
            r_dec     <= n_dec;
            r_cen_col <= col_cur;
            r_cen_row <= row_cur;
            r_drawing <= !done;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mcop_queue.sv
// Short octet queue between the front and back ends.
// Register-based FIFO of t_octet entries. Depends on mcop_pkg.
`default_nettype none

module mcop_queue import mcop_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_octet i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_nonempty,
    output t_octet      o_head
);

    t_octet              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push, do_pop;

    assign o_full     = (r_count == QCNT_W'(QDEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mcop_back.sv
// Back end: walks the eight symmetric pixels of the head octet, one per cycle
// when not stalled, into a valid/stall output register. Depends on mcop_pkg.
`default_nettype none

module mcop_back import mcop_pkg::*; #(
    parameter int COORD_WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_nonempty,
    input  wire t_octet                   i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [COORD_WIDTH-1:0] o_pixel_y,
    output logic [1:0]                    o_colour,
    output logic                          o_octet_last,
    output logic                          o_circle_done
);

    logic [2:0]       r_idx;
    logic             r_out_valid;
    logic [COORD_WIDTH-1:0] r_pixel_x, r_pixel_y;
    logic [1:0]       r_colour;
    logic             r_octet_last, r_circle_done;

    t_plan            plan;
    logic             load;
    logic [SUM_W-1:0] cx_ext, cy_ext, xo_ext, yo_ext, col_off, row_off;
    logic [SUM_W-1:0] n_col, n_row;

    assign load  = i_q_nonempty && (!r_out_valid || !i_out_stall);
    assign o_pop = load && (r_idx == LAST_IDX);

    // Form the current pixel from the plan table
    assign plan    = pixel_plan(r_idx);
    assign cx_ext  = {{(SUM_W-ARC_W){1'b0}}, i_head.cen_col};
    assign cy_ext  = {{(SUM_W-ARC_W){1'b0}}, i_head.cen_row};
    assign xo_ext  = {{(SUM_W-ARC_W){1'b0}}, i_head.arc_x};
    assign yo_ext  = {{(SUM_W-ARC_W){1'b0}}, i_head.arc_y};
    assign col_off = plan.swap ? yo_ext : xo_ext;
    assign row_off = plan.swap ? xo_ext : yo_ext;
    assign n_col   = plan.neg_col ? (cx_ext - col_off) : (cx_ext + col_off);
    assign n_row   = plan.neg_row ? (cy_ext - row_off) : (cy_ext + row_off);

    // Hold the pixel payload while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel_x     <= n_col[COORD_WIDTH-1:0];
            r_pixel_y     <= n_row[COORD_WIDTH-1:0];
            r_colour      <= plan.colour;
            r_octet_last  <= (r_idx == LAST_IDX);
            r_circle_done <= i_head.done;
        end
    end

    // Advance the pixel counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= r_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_colour      = r_colour;
    assign o_octet_last  = r_octet_last;
    assign o_circle_done = r_circle_done;

endmodule

`default_nettype wire

FILE: rtl/core/midpoint_circle_octant_plotter.sv
// Midpoint circle octant plotter, top level.
// An item's first pixel passes the octet queue and then the back-end output register.
// Each emitting item gives eight pixels, one per cycle from the back end when its
// output is not stalled; a two-entry octet queue lets the front take items meanwhile.
// Reset (synchronous, active low) clears the circle state, queue and output valid.
// Depends on mcop_pkg, mcop_front, mcop_queue, mcop_back.
`default_nettype none

module midpoint_circle_octant_plotter import mcop_pkg::*; #(
    parameter int COORD_WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_action,
    input  wire logic [ARC_W-1:0]         i_center_x,
    input  wire logic [ARC_W-1:0]         i_center_y,
    input  wire logic [ARC_W-1:0]         i_radius,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [COORD_WIDTH-1:0] o_pixel_y,
    output logic [1:0]                    o_colour,
    output logic                          o_octet_last,
    output logic                          o_circle_done
);

    logic   q_full, q_nonempty, push, pop;
    t_octet entry, head;

    // Accept and classify items
    mcop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (entry)
    );

    // Buffer octets between the two ends
    mcop_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    // Emit the eight pixels of each octet
    mcop_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_colour      (o_colour),
        .o_octet_last  (o_octet_last),
        .o_circle_done (o_circle_done)
    );

endmodule

`default_nettype wire
